>>> design/pctd_pkg.sv
// shared types, codes and defaults for the prefix code trie decoder
// no dependencies; imported by every other design file

package pctd_pkg;

  localparam int NODE_COUNT_DEF = 512;
  localparam int CODE_MAX_DEF   = 16;

  localparam int CMD_W    = 2;
  localparam int SYM_W    = 8;
  localparam int CODE_W   = 16;
  localparam int LEN_W    = 5;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DECODE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DEAD = 2'd2;

  typedef struct packed {
    logic accept;
    logic clear;
    logic dec_start;
    logic dec_commit;
    logic walk;
    logic alloc;
    logic reload;
    logic ins_emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic dec_has_result;
    logic walk_end;
    logic walk_miss;
    logic walk_full;
    logic alloc_last;
  } dp_stat_t;

endpackage

>>> design/prefix_code_trie_decoder_top.sv
// prefix code trie decoder, top level
// depends on pctd_pkg, pctd_ctrl and pctd_datapath
//
// input beats carry a command: clear the trie, insert one code with its
// symbol, or decode one message bit. in_stall is high whenever the block is
// busy; a beat is taken while in_valid is high and in_stall is low.
// result beats leave through a one-entry output register on the out_ side;
// a waiting result does not stop the next input beat from being taken, only
// the following result waits until out_stall drops.
// clear: no result. decode: for each bit, a table read of the next node,
// then its evaluation; a result follows a symbol or a last bit. insert:
// walks the levels, allocates the missing nodes, reloads the current node
// and emits, one table access per level through the single write and single
// read port of the node table; every insert gives one result.
// reset empties the trie, returns the walk to the root and drops any
// pending result. no clearing pass is needed, new nodes are written on
// allocation.

module prefix_code_trie_decoder_top #(
  parameter int NODE_COUNT = pctd_pkg::NODE_COUNT_DEF,
  parameter int CODE_MAX   = pctd_pkg::CODE_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pctd_pkg::CMD_W-1:0]      in_command,
  input  logic [pctd_pkg::SYM_W-1:0]      in_symbol_in,
  input  logic [pctd_pkg::CODE_W-1:0]     in_code_bits,
  input  logic [pctd_pkg::LEN_W-1:0]      in_code_length,
  input  logic                            in_bit_value,
  input  logic                            in_last_bit,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pctd_pkg::SYM_W-1:0]      out_symbol_out,
  output logic                            out_symbol_valid,
  output logic                            out_message_end,
  output logic [pctd_pkg::STATUS_W-1:0]   out_status
);
  import pctd_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  pctd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .stat       (stat),
    .cmd        (cmd),
    .in_stall   (in_stall)
  );

  pctd_datapath #(
    .NODE_COUNT (NODE_COUNT),
    .CODE_MAX   (CODE_MAX)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_symbol_in     (in_symbol_in),
    .in_code_bits     (in_code_bits),
    .in_code_length   (in_code_length),
    .in_bit_value     (in_bit_value),
    .in_last_bit      (in_last_bit),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_symbol_out   (out_symbol_out),
    .out_symbol_valid (out_symbol_valid),
    .out_message_end  (out_message_end),
    .out_status       (out_status)
  );

endmodule

>>> design/pctd_ctrl.sv
// sequencing state machine for the prefix code trie decoder
// depends on pctd_pkg; drives commands into pctd_datapath

module pctd_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [pctd_pkg::CMD_W-1:0]   in_command,
  input  pctd_pkg::dp_stat_t           stat,
  output pctd_pkg::ctl_cmd_t           cmd,
  output logic                         in_stall
);
  import pctd_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DEC    = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_ALLOC  = 3'd3;
  localparam logic [2:0] S_RELOAD = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.accept = accept;
        if (accept) begin
          case (in_command)
            CMD_CLEAR: begin
              cmd.clear = 1'b1;
            end
            CMD_INSERT: begin
              state_nxt = S_WALK;
            end
            CMD_DECODE: begin
              cmd.dec_start = 1'b1;
              state_nxt     = S_DEC;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_DEC: begin
        if (!stat.dec_has_result || stat.out_free) begin
          cmd.dec_commit = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_end || stat.walk_full) begin
          state_nxt = S_RELOAD;
        end else if (stat.walk_miss) begin
          state_nxt = S_ALLOC;
        end
      end
      S_ALLOC: begin
        cmd.alloc = 1'b1;
        if (stat.alloc_last) begin
          state_nxt = S_RELOAD;
        end
      end
      S_RELOAD: begin
        cmd.reload = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.ins_emit = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/pctd_datapath.sv
// node table, walk registers and result register of the prefix code trie decoder
// depends on pctd_pkg; commanded by pctd_ctrl

module pctd_datapath #(
  parameter int NODE_COUNT = pctd_pkg::NODE_COUNT_DEF,
  parameter int CODE_MAX   = pctd_pkg::CODE_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pctd_pkg::ctl_cmd_t              cmd,
  output pctd_pkg::dp_stat_t              stat,
  input  logic [pctd_pkg::SYM_W-1:0]      in_symbol_in,
  input  logic [pctd_pkg::CODE_W-1:0]     in_code_bits,
  input  logic [pctd_pkg::LEN_W-1:0]      in_code_length,
  input  logic                            in_bit_value,
  input  logic                            in_last_bit,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [pctd_pkg::SYM_W-1:0]      out_symbol_out,
  output logic                            out_symbol_valid,
  output logic                            out_message_end,
  output logic [pctd_pkg::STATUS_W-1:0]   out_status
);
  import pctd_pkg::*;

  localparam int IW  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int NUW = $clog2(NODE_COUNT + 1);
  localparam int KW  = $clog2(CODE_MAX + 1);
  localparam int SW  = ((NUW > KW) ? NUW : KW) + 1;
  localparam int EW  = SYM_W + 2 * IW;

  // node table, entry 0 lives in the root registers
  logic [EW-1:0] mem [NODE_COUNT];
  logic [EW-1:0] rd_data_r;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  logic [SYM_W-1:0] root_sym_r, root_sym_nxt;
  logic [IW-1:0]    root_left_r, root_left_nxt;
  logic [IW-1:0]    root_right_r, root_right_nxt;

  logic [NUW-1:0]   nodes_used_r, nodes_used_nxt;
  logic [IW-1:0]    cur_r, cur_nxt;
  logic [EW-1:0]    cur_ent_r, cur_ent_nxt;
  logic             dead_r, dead_nxt;

  logic [IW-1:0]     n_r, n_nxt;
  logic [KW-1:0]     k_r, k_nxt;
  logic [KW-1:0]     len_r, len_nxt;
  logic [SYM_W-1:0]  sym_r, sym_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic              bit_r, bit_nxt;
  logic              last_r, last_nxt;
  logic              full_r, full_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]    out_sym_r, out_sym_nxt;
  logic                out_sv_r, out_sv_nxt;
  logic                out_end_r, out_end_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  logic [SYM_W-1:0] rd_sym;
  logic [IW-1:0]    rd_left, rd_right;
  logic [IW-1:0]    cv_left, cv_right;
  logic [KW-1:0]    len_in;

  logic [IW-1:0]    dec_c;
  logic             dec_miss, dec_leaf, dec_emit, dec_dead, dec_has_result;

  logic [SYM_W-1:0] e_sym;
  logic [IW-1:0]    e_left, e_right;
  logic [5:0]       k6;
  logic             code_bit;
  logic [IW-1:0]    walk_c;
  logic             walk_end, walk_miss, walk_full;
  logic [KW-1:0]    need;
  logic [SW-1:0]    need_sum;
  logic [IW-1:0]    nu_idx, nu_next_idx;
  logic [NUW-1:0]   nu_inc;
  logic             alloc_last;
  logic             out_free;

  assign rd_sym   = rd_data_r[EW-1 -: SYM_W];
  assign rd_left  = rd_data_r[2*IW-1 -: IW];
  assign rd_right = rd_data_r[IW-1:0];

  assign cv_left  = (cur_r == '0) ? root_left_r  : cur_ent_r[2*IW-1 -: IW];
  assign cv_right = (cur_r == '0) ? root_right_r : cur_ent_r[IW-1:0];

  assign len_in = ({1'b0, in_code_length} > 6'(CODE_MAX)) ? KW'(CODE_MAX)
                                                           : KW'(in_code_length);

  // decode step
  assign dec_c          = bit_r ? cv_right : cv_left;
  assign dec_miss       = (dec_c == '0);
  assign dec_leaf       = (rd_left == '0) && (rd_right == '0);
  assign dec_emit       = !dead_r && !dec_miss && dec_leaf;
  assign dec_dead       = dead_r || dec_miss;
  assign dec_has_result = dec_emit || last_r;

  // insert walk
  assign e_sym    = (n_r == '0) ? root_sym_r   : rd_sym;
  assign e_left   = (n_r == '0) ? root_left_r  : rd_left;
  assign e_right  = (n_r == '0) ? root_right_r : rd_right;
  assign k6       = 6'(k_r);
  assign code_bit = (k6 < 6'(CODE_W)) ? code_r[k6[3:0]] : 1'b0;
  assign walk_c   = code_bit ? e_right : e_left;
  assign walk_end = (k_r == len_r);
  assign walk_miss = !walk_end && (walk_c == '0);
  assign need     = len_r - k_r;
  assign need_sum = SW'(nodes_used_r) + SW'(need);
  assign walk_full = walk_miss && (need_sum > SW'(NODE_COUNT));

  assign nu_idx      = nodes_used_r[IW-1:0];
  assign nu_inc      = nodes_used_r + NUW'(1);
  assign nu_next_idx = nu_inc[IW-1:0];
  assign alloc_last  = (k_r == len_r);

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    stat                = '0;
    stat.out_free       = out_free;
    stat.dec_has_result = dec_has_result;
    stat.walk_end       = walk_end;
    stat.walk_miss      = walk_miss;
    stat.walk_full      = walk_full;
    stat.alloc_last     = alloc_last;
  end

  // table port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    if (cmd.dec_start) begin
      rd_en   = 1'b1;
      rd_addr = in_bit_value ? cv_right : cv_left;
    end else if (cmd.reload) begin
      rd_en   = 1'b1;
      rd_addr = cur_r;
    end else if (cmd.walk) begin
      if (walk_end) begin
        wr_en   = 1'b1;
        wr_addr = n_r;
        wr_data = {sym_r, e_left, e_right};
      end else if (walk_miss) begin
        if (!walk_full) begin
          wr_en   = 1'b1;
          wr_addr = n_r;
          wr_data = code_bit ? {e_sym, e_left, nu_idx} : {e_sym, nu_idx, e_right};
        end
      end else begin
        rd_en   = 1'b1;
        rd_addr = walk_c;
      end
    end else if (cmd.alloc) begin
      wr_en   = 1'b1;
      wr_addr = nu_idx;
      if (alloc_last) begin
        wr_data = {sym_r, {IW{1'b0}}, {IW{1'b0}}};
      end else if (code_bit) begin
        wr_data = {{SYM_W{1'b0}}, {IW{1'b0}}, nu_next_idx};
      end else begin
        wr_data = {{SYM_W{1'b0}}, nu_next_idx, {IW{1'b0}}};
      end
    end
  end

  always_comb begin
    root_sym_nxt   = root_sym_r;
    root_left_nxt  = root_left_r;
    root_right_nxt = root_right_r;
    nodes_used_nxt = nodes_used_r;
    cur_nxt        = cur_r;
    cur_ent_nxt    = cur_ent_r;
    dead_nxt       = dead_r;
    n_nxt          = n_r;
    k_nxt          = k_r;
    len_nxt        = len_r;
    sym_nxt        = sym_r;
    code_nxt       = code_r;
    bit_nxt        = bit_r;
    last_nxt       = last_r;
    full_nxt       = full_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_sym_nxt    = out_sym_r;
    out_sv_nxt     = out_sv_r;
    out_end_nxt    = out_end_r;
    out_status_nxt = out_status_r;

    if (cmd.accept) begin
      sym_nxt  = in_symbol_in;
      code_nxt = in_code_bits;
      len_nxt  = len_in;
      bit_nxt  = in_bit_value;
      last_nxt = in_last_bit;
      n_nxt    = '0;
      k_nxt    = '0;
      full_nxt = 1'b0;
    end

    if (cmd.clear) begin
      root_sym_nxt   = '0;
      root_left_nxt  = '0;
      root_right_nxt = '0;
      nodes_used_nxt = NUW'(1);
      cur_nxt        = '0;
      dead_nxt       = 1'b0;
    end

    if (wr_en && (wr_addr == '0)) begin
      root_sym_nxt   = wr_data[EW-1 -: SYM_W];
      root_left_nxt  = wr_data[2*IW-1 -: IW];
      root_right_nxt = wr_data[IW-1:0];
    end

    if (cmd.walk) begin
      if (walk_miss) begin
        if (walk_full) begin
          full_nxt = 1'b1;
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end else if (!walk_end) begin
        n_nxt = walk_c;
        k_nxt = k_r + KW'(1);
      end
    end

    if (cmd.alloc) begin
      nodes_used_nxt = nu_inc;
      if (!alloc_last) begin
        k_nxt = k_r + KW'(1);
      end
    end

    if (cmd.dec_commit) begin
      if (last_r) begin
        dead_nxt = 1'b0;
        cur_nxt  = '0;
      end else if (dec_dead) begin
        dead_nxt = 1'b1;
        cur_nxt  = '0;
      end else if (dec_leaf) begin
        cur_nxt = '0;
      end else begin
        cur_nxt     = dec_c;
        cur_ent_nxt = rd_data_r;
      end
      if (dec_has_result) begin
        out_valid_nxt  = 1'b1;
        out_sym_nxt    = dec_emit ? rd_sym : '0;
        out_sv_nxt     = dec_emit;
        out_end_nxt    = last_r;
        out_status_nxt = (last_r && dec_dead) ? STATUS_DEAD : STATUS_OK;
      end
    end

    if (cmd.ins_emit) begin
      // refresh the cached current node, the insert may have changed it
      cur_ent_nxt    = rd_data_r;
      out_valid_nxt  = 1'b1;
      out_sym_nxt    = '0;
      out_sv_nxt     = 1'b0;
      out_end_nxt    = 1'b0;
      out_status_nxt = full_r ? STATUS_FULL : STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr != '0)) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_sym_r   <= '0;
      root_left_r  <= '0;
      root_right_r <= '0;
      nodes_used_r <= NUW'(1);
      cur_r        <= '0;
      dead_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      root_sym_r   <= root_sym_nxt;
      root_left_r  <= root_left_nxt;
      root_right_r <= root_right_nxt;
      nodes_used_r <= nodes_used_nxt;
      cur_r        <= cur_nxt;
      dead_r       <= dead_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_ent_r    <= cur_ent_nxt;
    n_r          <= n_nxt;
    k_r          <= k_nxt;
    len_r        <= len_nxt;
    sym_r        <= sym_nxt;
    code_r       <= code_nxt;
    bit_r        <= bit_nxt;
    last_r       <= last_nxt;
    full_r       <= full_nxt;
    out_sym_r    <= out_sym_nxt;
    out_sv_r     <= out_sv_nxt;
    out_end_r    <= out_end_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_symbol_out   = out_sym_r;
  assign out_symbol_valid = out_sv_r;
  assign out_message_end  = out_end_r;
  assign out_status       = out_status_r;

endmodule
